// ===== src/msq_pkg.sv =====
// Shared field widths, bus layout and score constants for the maximal square scan unit.
package msq_pkg;

    // Field widths
    localparam int CFG_W     = 11;
    localparam int SCORE_W   = 11;
    localparam int ROW_OUT_W = 10;
    localparam int COL_OUT_W = 10;

    // Result bus layout, lowest bit up
    localparam int SCORE_LSB     = 0;
    localparam int BEST_SIZE_LSB = SCORE_LSB + SCORE_W;
    localparam int BEST_ROW_LSB  = BEST_SIZE_LSB + SCORE_W;
    localparam int BEST_COL_LSB  = BEST_ROW_LSB + ROW_OUT_W;
    localparam int M_FIELDS_W    = BEST_COL_LSB + COL_OUT_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int S_TDATA_W     = 8;

    // Largest score the field can carry
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef logic [SCORE_W-1:0] t_score;

endpackage

// ===== src/msq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/maximal_square_scan_unit.sv =====
// Top level of the maximal square scan unit: line buffer, score stage and result register.
//
//  channel   | direction | transfers             | carries
//  ----------+-----------+-----------------------+------------------------------------------
//  s_axis    | in        | one cell              | tdata[0] cell_free, tlast last_cell
//  m_axis    | out       | one result per cell   | tdata score/best size/row/col, tlast done
//  cfg       | in        | write grid_columns    | i_cfg_wdata, taken when i_cfg_we is high
//
// One cell per cycle sustained while m_axis takes every result; a result is offered on m_axis
// once the score stage advances: the previous-row line buffer read and the score stage register
// at acceptance, and the score is then formed straight into the result register. Reset clears counters,
// neighbour and best registers; the line buffer is not cleared and needs no clearing pass.
// A stall on m_axis holds the result register and backs up to s_axis only once the score
// stage is also full.
module maximal_square_scan_unit
    import msq_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // cfg
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,     // grid_columns
    // s_axis
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [0] cell_free, [7:1] zero
    input  logic                 i_s_axis_tlast,  // last_cell
    // m_axis
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [10:0] cell_score, [21:11] best_size,
                                                  // [31:22] best_row, [41:32] best_column,
                                                  // [47:42] zero
    output logic                 o_m_axis_tlast   // grid_done
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int NW = CW + 1;
    localparam logic [NW-1:0] COLS_RESET =
        (MAX_COLUMNS < 1024) ? NW'(MAX_COLUMNS) : NW'(1024);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    // Configuration and scan position
    logic [NW-1:0] r_cols, n_cols;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Score stage
    logic          r_s1_valid;
    logic          r_s1_free;
    logic          r_s1_last;
    logic          r_s1_edge;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_fwd;
    t_score        r_fwd_score;

    // Neighbour and best registers
    t_score        r_left;
    t_score        r_diag;
    t_score        r_best;
    logic [RW-1:0] r_best_row;
    logic [CW-1:0] r_best_col;

    // Result register
    logic          r_out_valid;
    t_score        r_out_score;
    t_score        r_out_best;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;
    logic          r_out_last;

    logic          acc;
    logic          s1_adv;
    logic          wrap;
    t_score        ram_q;
    t_score        up;
    t_score        nb_min;
    t_score        score;
    logic          upd;
    t_score        n_best;
    logic [RW-1:0] n_best_row;
    logic [CW-1:0] n_best_col;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;

    // Handshake
    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    // Clamp the column count into 1..MAX_COLUMNS
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cols = NW'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_COLUMNS)) begin
            n_cols = NW'(MAX_COLUMNS);
        end else begin
            n_cols = NW'(i_cfg_wdata);
        end
    end

    assign wrap = (NW'(r_col) + NW'(1)) >= r_cols;

    // Previous-row line buffer: read at acceptance, written as the score leaves
    msq_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (score),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // Score: take forwarded value when the same entry was written on the read edge
    always_comb begin
        up     = r_fwd ? r_fwd_score : ram_q;
        nb_min = (up < r_left) ? up : r_left;
        nb_min = (nb_min < r_diag) ? nb_min : r_diag;
        if (!r_s1_free) begin
            score = '0;
        end else if (r_s1_edge) begin
            score = t_score'(1);
        end else if (nb_min == SCORE_MAX) begin
            score = SCORE_MAX;
        end else begin
            score = nb_min + t_score'(1);
        end
    end

    // Running best, first cell in scan order wins ties
    always_comb begin
        upd        = score > r_best;
        n_best     = upd ? score : r_best;
        n_best_row = upd ? r_s1_row : r_best_row;
        n_best_col = upd ? r_s1_col : r_best_col;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= COLS_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_left      <= '0;
            r_diag      <= '0;
            r_best      <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cols <= n_cols;
            end
            // Advance the scan position
            if (acc) begin
                if (i_s_axis_tlast) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (wrap) begin
                    r_col <= '0;
                    if (r_row != ROW_LAST) begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
                r_fwd <= s1_adv && (r_s1_col == r_col);
            end
            // Score stage occupancy
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // Update neighbours and best; drop all at the end of a grid
            if (s1_adv) begin
                if (r_s1_last) begin
                    r_left     <= '0;
                    r_diag     <= '0;
                    r_best     <= '0;
                    r_best_row <= '0;
                    r_best_col <= '0;
                end else begin
                    r_left     <= score;
                    r_diag     <= up;
                    r_best     <= n_best;
                    r_best_row <= n_best_row;
                    r_best_col <= n_best_col;
                end
            end
            // Result register occupancy
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_free   <= i_s_axis_tdata[0];
            r_s1_last   <= i_s_axis_tlast;
            r_s1_edge   <= (r_row == '0) || (r_col == '0);
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_fwd_score <= score;
        end
        if (s1_adv) begin
            r_out_score <= score;
            r_out_best  <= n_best;
            r_out_row   <= n_best_row;
            r_out_col   <= n_best_col;
            r_out_last  <= r_s1_last;
        end
    end

    // Pack the result transaction
    assign row_ext = 32'(r_out_row);
    assign col_ext = 32'(r_out_col);

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[SCORE_LSB     +: SCORE_W]   = r_out_score;
        o_m_axis_tdata[BEST_SIZE_LSB +: SCORE_W]   = r_out_best;
        o_m_axis_tdata[BEST_ROW_LSB  +: ROW_OUT_W] = row_ext[ROW_OUT_W-1:0];
        o_m_axis_tdata[BEST_COL_LSB  +: COL_OUT_W] = col_ext[COL_OUT_W-1:0];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== src/msq_checker.sv =====
// Port-level checker for the maximal square scan unit, bound to the top level.
module msq_checker
    import msq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input logic                 i_s_axis_tlast,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast
);

    t_score             cell_score;
    t_score             best_size;
    logic [ROW_OUT_W-1:0] best_row;
    logic [COL_OUT_W-1:0] best_col;

    assign cell_score = o_m_axis_tdata[SCORE_LSB     +: SCORE_W];
    assign best_size  = o_m_axis_tdata[BEST_SIZE_LSB +: SCORE_W];
    assign best_row   = o_m_axis_tdata[BEST_ROW_LSB  +: ROW_OUT_W];
    assign best_col   = o_m_axis_tdata[BEST_COL_LSB  +: COL_OUT_W];

    // No result is offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered straight after reset");

    // A waiting cell transaction holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tlast))
        else $error("waiting cell changed");

    // A stalled result transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // The running best covers the score reported with it
    a_best_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> best_size >= cell_score)
        else $error("best size below cell score");

    // No position is reported while no square has been found
    a_empty_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && best_size == '0 |-> best_row == '0 && best_col == '0)
        else $error("position set with zero best size");

endmodule

bind maximal_square_scan_unit msq_checker u_msq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/maximal_square_scan_unit_tb.sv =====
// Self-checking stream testbench, maximal square scan unit: directed table, fixed runs, random grids.
module maximal_square_scan_unit_tb;
    import msq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int RANDOM_CELLS = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 160;

    typedef struct packed {
        t_score               score;
        t_score               best;
        logic [ROW_OUT_W-1:0] best_r;
        logic [COL_OUT_W-1:0] best_c;
        logic                 done;
    } t_square_result;

    // Fixed answer for one cell, used only where it is known at a glance
    typedef struct packed {
        bit             typed;
        t_square_result want;
    } t_fixed_answer;

    typedef struct packed {
        bit                   free;
        bit                   last;
        bit                   typed;
        t_score               score;
        t_score               best;
        logic [ROW_OUT_W-1:0] best_r;
        logic [COL_OUT_W-1:0] best_c;
    } t_stim_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // [0] cell_free, rest zero
    logic                 i_s_axis_tlast  = 1'b0; // last_cell
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // cell_score, best_size, best_row, best_column
    logic                 o_m_axis_tlast;        // grid_done

    maximal_square_scan_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Directed cells, grid of three columns; typed rows carry their known result
    t_stim_row directed_rows [20] = '{
        '{1'b1, 1'b0, 1'b1, 11'd1, 11'd1, 10'd0, 10'd0}, // first free cell sets the best
        '{1'b0, 1'b0, 1'b1, 11'd0, 11'd1, 10'd0, 10'd0}, // obstacle scores zero
        '{1'b1, 1'b0, 1'b1, 11'd1, 11'd1, 10'd0, 10'd0}, // tie leaves the best in place
        '{1'b1, 1'b0, 1'b1, 11'd1, 11'd1, 10'd0, 10'd0}, // first column scores one
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0}, // obstacle above
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0}, // first square of side two
        '{1'b1, 1'b1, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0}, // end of grid
        '{1'b0, 1'b0, 1'b1, 11'd0, 11'd0, 10'd0, 10'd0}, // fresh grid, best still zero
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b0, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0},
        '{1'b1, 1'b1, 1'b0, 11'd0, 11'd0, 10'd0, 10'd0}, // end of grid
        '{1'b1, 1'b1, 1'b1, 11'd1, 11'd1, 10'd0, 10'd0}  // single-cell grid
    };

    // Scan state mirrored from the block
    logic [CFG_W-1:0]     grid_cols = 11'd1024;
    t_score               line_buf [MAX_COLS] = '{default: '0};
    t_score               left_sc   = '0;
    t_score               diag_sc   = '0;
    t_score               best_sz   = '0;
    logic [ROW_OUT_W-1:0] row_cnt   = '0;
    logic [ROW_OUT_W-1:0] best_r    = '0;
    logic [COL_OUT_W-1:0] col_cnt   = '0;
    logic [COL_OUT_W-1:0] best_c    = '0;

    t_square_result awaited_results [$];
    t_fixed_answer  fixed_answers [$];
    int             results_checked = 0;
    int             mismatches      = 0;
    int             cycle_count     = 0;

    // Grid generator state, owned by the sender
    int cells_accepted = 0;
    int eff_cols       = MAX_COLS;
    bit in_grid        = 1'b0;
    int cells_left     = 0;
    int free_pct       = 90;

    // Receiver state
    int seen_results = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int calm_left    = 0;
    bit calm         = 1'b0;
    bit held         = 1'b0;

    // Score one cell and advance the scan, as the block does
    function automatic t_square_result score_cell(input logic free, input logic last);
        int unsigned    cols;
        int unsigned    col;
        int unsigned    up;
        int unsigned    sc;
        t_square_result res;
        cols = (grid_cols == 0) ? 1 : (grid_cols > MAX_COLS) ? MAX_COLS : grid_cols;
        col  = col_cnt;
        up   = line_buf[col];
        if (!free) begin
            sc = 0;
        end else if (row_cnt == 0 || col == 0) begin
            sc = 1;
        end else begin
            sc = (up < left_sc) ? up : left_sc;
            if (diag_sc < sc) sc = diag_sc;
            sc = (sc + 1 > SCORE_MAX) ? SCORE_MAX : sc + 1;
        end
        line_buf[col] = t_score'(sc);
        diag_sc       = t_score'(up);
        left_sc       = t_score'(sc);
        if (sc > best_sz) begin
            best_sz = t_score'(sc);
            best_r  = row_cnt;
            best_c  = COL_OUT_W'(col);
        end
        res.score  = t_score'(sc);
        res.best   = best_sz;
        res.best_r = best_r;
        res.best_c = best_c;
        res.done   = last;
        // Clear the scan after the last cell, else step the column and wrap rows
        if (last) begin
            left_sc = '0;
            diag_sc = '0;
            row_cnt = '0;
            col_cnt = '0;
            best_sz = '0;
            best_r  = '0;
            best_c  = '0;
        end else if (col + 1 >= cols) begin
            col_cnt = '0;
            if (row_cnt + 1 < MAX_ROWS) row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = COL_OUT_W'(col + 1);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes and cell transactions, then check each result transaction
    always @(posedge i_clk) begin : track_cells
        t_square_result got;
        t_square_result want;
        t_fixed_answer  fixed;
        if (i_rst_n) begin
            if (i_cfg_we) grid_cols = i_cfg_wdata;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                fixed = fixed_answers.pop_front();
                got   = score_cell(i_s_axis_tdata[0], i_s_axis_tlast);
                awaited_results.push_back(fixed.typed ? fixed.want : got);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, got %h / %b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("cell_score", want.score,
                                o_m_axis_tdata[SCORE_LSB +: SCORE_W]);
                    check_field("best_size", want.best,
                                o_m_axis_tdata[BEST_SIZE_LSB +: SCORE_W]);
                    check_field("best_row", 11'(want.best_r),
                                11'(o_m_axis_tdata[BEST_ROW_LSB +: ROW_OUT_W]));
                    check_field("best_column", 11'(want.best_c),
                                11'(o_m_axis_tdata[BEST_COL_LSB +: COL_OUT_W]));
                    check_field("grid_done", 11'(want.done), 11'(o_m_axis_tlast));
                end
                results_checked <= results_checked + 1;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) seen_results++;
            if (calm_left == 0) begin
                calm      = ($urandom_range(3) == 0);
                calm_left = $urandom_range(50, 400);
            end else begin
                calm_left--;
            end
            if (!held && seen_results >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 25) begin
                stall_left = ($urandom_range(19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Shrink only while a grid is open, so no unwritten line-buffer entry is read
    function automatic int pick_columns();
        if (in_grid) return $urandom_range(eff_cols);
        case ($urandom_range(15))
            0:       return 0;
            1:       return MAX_COLS;
            2:       return 2047;
            3:       return $urandom_range(MAX_COLS + 1, 2046);
            4, 5:    return $urandom_range(13, 64);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // Choose the length and density of the next grid
    function automatic void start_grid();
        int rows;
        if (eff_cols > 64) begin
            cells_left = $urandom_range(1, 48);
        end else begin
            if (eff_cols > 16) rows = $urandom_range(1, 4);
            else if ($urandom_range(9) == 0) rows = $urandom_range(12, 30);
            else rows = $urandom_range(1, 10);
            cells_left = rows * eff_cols;
            if ($urandom_range(3) == 0) cells_left -= $urandom_range(eff_cols - 1);
        end
        free_pct = ($urandom_range(4) == 0) ? $urandom_range(30, 80) : $urandom_range(85, 100);
    endfunction

    task automatic wait_drained();
        while (results_checked != cells_accepted) @(posedge i_clk);
    endtask

    // Write the column count once the block has gone quiet
    task automatic write_columns(input int columns);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(columns);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eff_cols = (columns == 0) ? 1 : (columns > MAX_COLS) ? MAX_COLS : columns;
    endtask

    // Offer one cell and hold it until its transaction completes
    task automatic push_cell(input bit free, input bit last, input bit typed,
                             input t_square_result want, input int gap);
        fixed_answers.push_back('{typed, want});
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W - 1){1'b0}}, free};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        cells_accepted++;
    endtask

    task automatic run_phase(input int columns, input int n_cells, input int grid_len,
                             input bit steady);
        bit free;
        bit last;
        write_columns(columns);
        if (grid_len > 0) begin
            cells_left = grid_len;
            free_pct   = 80;
        end
        repeat (n_cells) begin
            if (cells_left == 0) start_grid();
            free = ($urandom_range(99) < free_pct);
            last = (cells_left == 1);
            cells_left--;
            in_grid = !last;
            push_cell(free, last, 1'b0, '0, pick_gap(steady));
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        t_stim_row      row;
        t_square_result want;
        int             random_cells;
        int             n;
        random_cells = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        write_columns(3);
        foreach (directed_rows[i]) begin
            row         = directed_rows[i];
            want.score  = row.score;
            want.best   = row.best;
            want.best_r = row.best_r;
            want.best_c = row.best_c;
            want.done   = row.last;
            push_cell(row.free, row.last, row.typed, want, pick_gap(1'b0));
        end
        i_s_axis_tvalid <= 1'b0;

        // One column, more rows than the row counter holds
        run_phase(1, 1030, 1030, 1'b1);
        // Out-of-range count clamps to the widest row
        run_phase(2047, 40, 40, 1'b1);

        // Random grids, column changes between bursts, some of them mid-row
        while (random_cells < RANDOM_CELLS) begin
            n = $urandom_range(15, 70);
            run_phase(pick_columns(), n, 0, $urandom_range(3) == 0);
            random_cells += n;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== maximal_square_scan_unit.f =====
src/msq_pkg.sv
src/msq_ram.sv
src/maximal_square_scan_unit.sv
src/msq_checker.sv
tb/maximal_square_scan_unit_tb.sv
